FILE: rtl/lmr_pkg.sv
// ----------------------------------------------------------------------------
// lmr_pkg
// Shared types, widths and helper functions of the lattice modular reduction
// unit.
// ----------------------------------------------------------------------------
package lmr_pkg;

    // wide enough for twice the largest supported modulus
    localparam int MOD_W  = 24;
    localparam int TQ_W   = 33;
    localparam int MB_W   = MOD_W + 1;
    localparam int PROD_W = TQ_W + MB_W;

    typedef enum logic [2:0] {
        KIND_MONT = 3'd0,
        KIND_CRED = 3'd1,
        KIND_ADDQ = 3'd2,
        KIND_FRZ  = 3'd3,
        KIND_RED2 = 3'd4,
        KIND_ADD2 = 3'd5,
        KIND_FRZ2 = 3'd6
    } kind_t;

    // unused kind code, result is zero
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        kind_t                     kind;
        logic [63:0]               value;
        logic signed [PROD_W-1:0]  prod;
    } prod_item_t;

    // inverse of an odd q modulo 2^32 by newton iteration
    function automatic logic [31:0] qinv_of(input logic [31:0] q);
        logic [31:0] x;
        x = q;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - q * x);
        end
        return x;
    endfunction

endpackage

FILE: rtl/lmr_mul_front.sv
// ----------------------------------------------------------------------------
// lmr_mul_front
// Two multiplier stages: the first forms t for montgomery or the reciprocal
// quotient estimate, the second multiplies that by the modulus.
// ----------------------------------------------------------------------------
module lmr_mul_front import lmr_pkg::*; #(
    parameter int MODULUS = 64513
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  kind_t       in_kind,
    input  logic [63:0] in_value,
    output logic        out_valid,
    input  logic        out_ready,
    output prod_item_t  out_item
);

    localparam logic [MOD_W-1:0] MOD_Q    = MOD_W'(MODULUS);
    localparam logic [MOD_W-1:0] MOD_DQ   = MOD_W'(2 * MODULUS);
    localparam logic [31:0]      QINV     = qinv_of(32'(MODULUS));
    localparam logic [31:0]      RECIP_Q  = 32'(64'h1_0000_0000 / MODULUS);
    localparam logic [31:0]      RECIP_DQ = 32'(64'h1_0000_0000 / (2 * MODULUS));

    logic                     valid_a_reg;
    kind_t                    kind_a_reg;
    logic [63:0]              value_a_reg;
    logic [63:0]              p1_a_reg;
    logic [63:0]              p1_next;
    logic                     valid_b_reg;
    prod_item_t               item_b_reg;
    prod_item_t               item_b_next;
    logic                     ready_a;
    logic                     ready_b;
    logic                     dq_in;
    logic                     dq_a;
    logic [31:0]              m1_a;
    logic [31:0]              m1_b;
    logic signed [TQ_W-1:0]   t_op;
    logic signed [MB_W-1:0]   m_op;

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    // stage a: first product
    always_comb begin
        dq_in = (in_kind == KIND_RED2) || (in_kind == KIND_ADD2) || (in_kind == KIND_FRZ2);
        if (in_kind == KIND_MONT) begin
            m1_a = in_value[31:0];
            m1_b = QINV;
        end else begin
            m1_a = {~in_value[31], in_value[30:0]};
            m1_b = dq_in ? RECIP_DQ : RECIP_Q;
        end
        p1_next = 64'(m1_a) * 64'(m1_b);
    end

    // stage b: product with the modulus
    always_comb begin
        dq_a = (kind_a_reg == KIND_RED2) || (kind_a_reg == KIND_ADD2)
            || (kind_a_reg == KIND_FRZ2);
        if (kind_a_reg == KIND_MONT) begin
            t_op = {p1_a_reg[31], p1_a_reg[31:0]};
            m_op = {1'b0, MOD_Q};
        end else begin
            t_op = {1'b0, p1_a_reg[63:32]};
            m_op = {1'b0, dq_a ? MOD_DQ : MOD_Q};
        end
        item_b_next.kind  = kind_a_reg;
        item_b_next.value = value_a_reg;
        item_b_next.prod  = t_op * m_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            kind_a_reg  <= in_kind;
            value_a_reg <= in_value;
            p1_a_reg    <= p1_next;
        end
        if (ready_b && valid_a_reg) begin
            item_b_reg <= item_b_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_item  = item_b_reg;

endmodule

FILE: rtl/lmr_reduce_back.sv
// ----------------------------------------------------------------------------
// lmr_reduce_back
// Remainder correction, range mapping and result selection, with the
// output register.
// ----------------------------------------------------------------------------
module lmr_reduce_back import lmr_pkg::*; #(
    parameter int MODULUS = 64513
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  prod_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_result
);

    localparam logic [MOD_W-1:0] MOD_Q   = MOD_W'(MODULUS);
    localparam logic [MOD_W-1:0] MOD_DQ  = MOD_W'(2 * MODULUS);
    localparam logic [MOD_W-1:0] OFS_Q   = MOD_W'(64'h8000_0000 % MODULUS);
    localparam logic [MOD_W-1:0] OFS_DQ  = MOD_W'(64'h8000_0000 % (2 * MODULUS));

    logic              valid_c_reg;
    kind_t             kind_c_reg;
    logic [31:0]       a_c_reg;
    logic [31:0]       mont_c_reg;
    logic [MOD_W-1:0]  rem_c_reg;
    logic [31:0]       mont_next;
    logic [MOD_W-1:0]  rem_next;
    logic              valid_d_reg;
    logic [31:0]       result_reg;
    logic [31:0]       result_next;
    logic              ready_c;
    logic              ready_d;
    logic              dq_b;
    logic              dq_c;
    logic [63:0]       prod_ext;
    logic [MOD_W:0]    m_b;
    logic [MOD_W:0]    rem_raw;
    logic [MOD_W:0]    m_c;
    logic [MOD_W:0]    diff;
    logic [MOD_W:0]    red;
    logic [MOD_W:0]    top;
    logic [MOD_W:0]    cent;
    logic [31:0]       addneg;

    assign ready_d  = !valid_d_reg || out_ready;
    assign ready_c  = !valid_c_reg || ready_d;
    assign in_ready = ready_c;

    // stage c: montgomery high word and remainder below m
    always_comb begin
        dq_b = (in_item.kind == KIND_RED2) || (in_item.kind == KIND_ADD2)
            || (in_item.kind == KIND_FRZ2);
        m_b       = {1'b0, dq_b ? MOD_DQ : MOD_Q};
        prod_ext  = {{(64-PROD_W){in_item.prod[PROD_W-1]}}, in_item.prod};
        mont_next = in_item.value[63:32] - prod_ext[63:32];
        rem_raw   = in_item.value[MOD_W:0] - in_item.prod[MOD_W:0];
        if (rem_raw >= m_b) begin
            rem_next = rem_raw[MOD_W-1:0] - m_b[MOD_W-1:0];
        end else begin
            rem_next = rem_raw[MOD_W-1:0];
        end
    end

    // stage d: undo the sign offset, map to range, select
    always_comb begin
        dq_c = (kind_c_reg == KIND_RED2) || (kind_c_reg == KIND_ADD2)
            || (kind_c_reg == KIND_FRZ2);
        m_c  = {1'b0, dq_c ? MOD_DQ : MOD_Q};
        diff = {1'b0, rem_c_reg} - {1'b0, dq_c ? OFS_DQ : OFS_Q};
        red  = diff[MOD_W] ? diff + m_c : diff;
        top  = (kind_c_reg == KIND_RED2) ? {1'b0, MOD_Q} : {2'b00, MOD_Q[MOD_W-1:1]};
        cent = (red > top) ? red - m_c : red;
        addneg = a_c_reg[31] ? a_c_reg + {{(31-MOD_W){1'b0}}, m_c} : a_c_reg;
        case (kind_c_reg)
            KIND_MONT: result_next = mont_c_reg;
            KIND_CRED,
            KIND_RED2: result_next = {{(31-MOD_W){cent[MOD_W]}}, cent};
            KIND_FRZ,
            KIND_FRZ2: result_next = {{(31-MOD_W){1'b0}}, red};
            KIND_ADDQ,
            KIND_ADD2: result_next = addneg;
            default:   result_next = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (ready_c) begin
                valid_c_reg <= in_valid;
            end
            if (ready_d) begin
                valid_d_reg <= valid_c_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_c && in_valid) begin
            kind_c_reg <= in_item.kind;
            a_c_reg    <= in_item.value[31:0];
            mont_c_reg <= mont_next;
            rem_c_reg  <= rem_next;
        end
        if (ready_d && valid_c_reg) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_d_reg;
    assign out_result = result_reg;

endmodule

FILE: rtl/lattice_modular_reduction_unit.sv
// ----------------------------------------------------------------------------
// lattice_modular_reduction_unit
// Montgomery, centered, conditional-add and freeze reduction of coefficients.
// ----------------------------------------------------------------------------
// usage
//   input channel: s_tdata carries the 64-bit signed operand, s_tuser the
//   operation kind (0 montgomery, 1 center reduce, 2 add q, 3 freeze,
//   4 reduce 2q, 5 add 2q, 6 freeze 2q, 7 gives zero)
//   output channel: m_tdata carries the 32-bit signed coefficient, one item
//   out for every item in, in order
//   pipeline: four register stages (two multiplier stages,
//   remainder correction, output register)
//   throughput: one item per cycle while m_tready stays high
//   reset: aresetn low at a clock edge empties the pipeline; no other state
//   stall: when m_tready is low the result holds, earlier empty stages keep
//   filling, and s_tready drops once every stage holds an item
// ----------------------------------------------------------------------------
module lattice_modular_reduction_unit import lmr_pkg::*; #(
    parameter int MODULUS = 64513
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result
);

    logic       mid_valid;
    logic       mid_ready;
    prod_item_t mid_item;

    lmr_mul_front #(
        .MODULUS (MODULUS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser)),
        .in_value  (s_tdata),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    lmr_reduce_back #(
        .MODULUS (MODULUS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_item    (mid_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

endmodule

FILE: rtl/lmr_checker.sv
// ----------------------------------------------------------------------------
// lmr_checker
// Port-level checks of the reduction unit, bound to the top level.
// ----------------------------------------------------------------------------
module lmr_checker import lmr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    logic acc;

    assign acc = s_tvalid && s_tready;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled item changed");

    // an empty output stage never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("item out right after reset");

    // unused kind gives zero when the sink stays ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && m_tready && s_tuser == KIND_UNUSED) ##1 m_tready ##1 m_tready
        ##1 m_tready |=> m_tvalid && m_tdata == 32'd0)
        else $error("unused kind not zero");

    // add q passes a non-negative operand unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && m_tready && s_tuser == KIND_ADDQ && !s_tdata[31]) ##1 m_tready
        ##1 m_tready ##1 m_tready |=> m_tvalid && m_tdata == $past(s_tdata[31:0], 4))
        else $error("add q changed a non-negative operand");

endmodule

bind lattice_modular_reduction_unit lmr_checker u_lmr_checker (.*);

FILE: test/tb_lattice_modular_reduction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_modular_reduction_unit
// Streams directed and random operands of every kind through the reduction
// unit with random source gaps and sink stalls, and checks each coefficient in
// order against a table entry or a predictor from the arithmetic definition.
// ----------------------------------------------------------------------------
module tb_lattice_modular_reduction_unit;
    import lmr_pkg::*;

    localparam int MODULUS = 64513;
    localparam longint Q_L = MODULUS;
    localparam longint TWO_Q = 2 * Q_L;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM = 1100;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        typed;
        logic [31:0] result;
    } directed_row_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [31:0] result;
    } coeff_entry_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // value
    logic [2:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // result

    coeff_entry_t pending_coeffs[$];
    int           mismatches = 0;
    int           coeffs_seen = 0;
    int           kind_seen[8];
    int           cycle_count = 0;
    bit           no_stall = 1'b0;

    function automatic logic [31:0] inverse_mod_2_32(input int q);
        logic [31:0] x;
        logic [31:0] p;
        x = 32'd1;
        for (int i = 1; i < 32; i++) begin
            p = 32'(q) * x;
            if (p[i]) begin
                x[i] = 1'b1;
            end
        end
        return x;
    endfunction

    localparam logic [31:0] QINV = inverse_mod_2_32(MODULUS);

    function automatic longint centered_mod(input longint a, input longint m,
                                            input longint top);
        longint t;
        t = a % m;
        if (t < 0) begin
            t += m;
        end
        if (t > top) begin
            t -= m;
        end
        return t;
    endfunction

    function automatic logic [31:0] reduce_coeff(input logic [2:0] kind,
                                                 input logic [63:0] value);
        longint      a;
        longint      r;
        longint      ts;
        logic [31:0] t;
        logic [63:0] d;
        a = longint'($signed(value[31:0]));
        case (kind)
            KIND_MONT: begin
                t = value[31:0] * QINV;
                ts = longint'($signed(t));
                d = value - 64'(ts * Q_L);
                r = longint'(d >> 32);
            end
            KIND_CRED: r = centered_mod(a, Q_L, Q_L >>> 1);
            KIND_ADDQ: r = (a < 0) ? a + Q_L : a;
            KIND_FRZ: begin
                r = centered_mod(a, Q_L, Q_L >>> 1);
                if (r < 0) begin
                    r += Q_L;
                end
            end
            KIND_RED2: r = centered_mod(a, TWO_Q, Q_L);
            KIND_ADD2: r = (a < 0) ? a + TWO_Q : a;
            KIND_FRZ2: begin
                r = centered_mod(a, TWO_Q, Q_L);
                if (r < 0) begin
                    r += TWO_Q;
                end
            end
            default: r = 0;
        endcase
        return r[31:0];
    endfunction

    // operand shapes that reach the interesting corners of each kind
    function automatic logic [63:0] pick_operand();
        longint v;
        case ($urandom_range(0, 5))
            0: v = longint'({$urandom, $urandom});
            1: v = longint'($urandom_range(0, 4 * MODULUS)) - 2 * Q_L;
            2: v = (longint'($urandom_range(0, 64000)) - 32000) * Q_L
                   + longint'($urandom_range(0, 4)) - 2;
            3: v = longint'({$urandom, $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0000})
                   + longint'($urandom_range(0, 15));
            4: v = (longint'($urandom_range(0, 2 * MODULUS)) - Q_L)
                   * (longint'($urandom_range(0, 2 * MODULUS)) - Q_L);
            default: v = longint'({$urandom, 32'($urandom_range(0, 3 * MODULUS))});
        endcase
        return v;
    endfunction

    lattice_modular_reduction_unit #(
        .MODULUS(MODULUS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        coeff_entry_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_coeffs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_tdata);
            end else begin
                e = pending_coeffs.pop_front();
                coeffs_seen++;
                kind_seen[e.kind]++;
                if (m_tdata !== e.result) begin
                    mismatches++;
                    $display("%0t: kind %0d value %h: expected %h, actual %h", $time,
                             e.kind, e.value, e.result, m_tdata);
                end
            end
        end
    end

    // sink side with random stalls
    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            hold = no_stall ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [63:0] value,
                             input logic typed, input logic [31:0] typed_result);
        int           gap;
        coeff_entry_t e;
        gap = no_stall ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        e.kind = kind;
        e.value = value;
        e.result = typed ? typed_result : reduce_coeff(kind, value);
        pending_coeffs.push_back(e);
        @(negedge aclk);
    endtask

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{KIND_MONT,   64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
        '{KIND_MONT,   64'h0000_FC01_0000_0000, 1'b1, 32'h0000_FC01},
        '{KIND_MONT,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
        '{KIND_MONT,   64'h8000_0000_0000_0000, 1'b1, 32'h8000_0000},
        '{KIND_MONT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
        '{KIND_CRED,   64'h0000_0000_0000_7E00, 1'b1, 32'h0000_7E00},
        '{KIND_CRED,   64'h0000_0000_0000_7E01, 1'b1, 32'hFFFF_8200},
        '{KIND_CRED,   64'hFFFF_FFFF_8000_0000, 1'b0, 32'h0},
        '{KIND_CRED,   64'h0000_0000_7FFF_FFFF, 1'b0, 32'h0},
        '{KIND_ADDQ,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0000_FC00},
        '{KIND_ADDQ,   64'h1234_5678_0000_0005, 1'b1, 32'h0000_0005},
        '{KIND_ADDQ,   64'h0000_0000_8000_0000, 1'b1, 32'h8000_FC01},
        '{KIND_FRZ,    64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
        '{KIND_FRZ,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0000_FC00},
        '{KIND_FRZ,    64'h0000_0000_7FFF_FFFF, 1'b0, 32'h0},
        '{KIND_RED2,   64'h0000_0000_0000_FC01, 1'b1, 32'h0000_FC01},
        '{KIND_RED2,   64'h0000_0000_0000_FC02, 1'b1, 32'hFFFF_0400},
        '{KIND_RED2,   64'hFFFF_FFFF_8000_0000, 1'b0, 32'h0},
        '{KIND_ADD2,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0001_F801},
        '{KIND_ADD2,   64'h0000_0000_7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{KIND_FRZ2,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0001_F801},
        '{KIND_FRZ2,   64'h0000_0000_7FFF_FFFF, 1'b0, 32'h0},
        '{KIND_FRZ2,   64'h0000_0000_0001_F802, 1'b1, 32'h0000_0000},
        '{KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0000_0000},
        '{KIND_UNUSED, 64'h0123_4567_89AB_CDEF, 1'b1, 32'h0000_0000}
    };

    initial begin
        int         pick;
        logic [2:0] kind;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].result);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // stretches with back-to-back traffic on both sides
            if (i % 150 == 0) begin
                no_stall = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 15);
            kind = (pick < 14) ? 3'(pick % 7) : KIND_UNUSED;
            send_item(kind, pick_operand(), 1'b0, 32'h0);
        end
        s_tvalid <= 1'b0;

        while (pending_coeffs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("checked %0d results: %0d directed rows and %0d random operands",
                 coeffs_seen, N_DIRECTED, N_RANDOM);
        $display("per kind 0..7: %0d %0d %0d %0d %0d %0d %0d %0d, mismatches %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7], mismatches);
        if (mismatches == 0 && pending_coeffs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: lattice_modular_reduction_unit.f
rtl/lmr_pkg.sv
rtl/lmr_mul_front.sv
rtl/lmr_reduce_back.sv
rtl/lattice_modular_reduction_unit.sv
rtl/lmr_checker.sv
test/tb_lattice_modular_reduction_unit.sv
